// ===== hw/rtl/qvr_pkg.sv =====
// Shared types and constants of the quaternion vector rotator.
// No dependencies; used by the top level and by its port checker.
package qvr_pkg;

	localparam int QUAT_W    = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_QX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QZ = 2'd3;

	// cycles from the accepting edge to the edge that takes the result
	localparam int PIPE_DEPTH = 6;

	typedef logic [QUAT_W-1:0] quat_reg_t;

endpackage

// ===== hw/rtl/quaternion_vector_rotate.sv =====
// Quaternion vector rotator: the result of each accepted item is presented on
// the rot outputs with done high for one cycle.
// Throughput one item per clock; busy is tied low because six register
// stages (operand capture, p*v products, cross product, p*u and w*u products,
// rounding sum, add and saturate) hold independent items at once.
// Reset clears every stage valid and loads the identity quaternion. Depends on qvr_pkg.
module quaternion_vector_rotate
	import qvr_pkg::*;
#(
	parameter int VEC_BITS  = 24,
	parameter int QUAT_FRAC = 14
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        mode,
	input  logic signed [VEC_BITS-1:0]  vec_x,
	input  logic signed [VEC_BITS-1:0]  vec_y,
	input  logic signed [VEC_BITS-1:0]  vec_z,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [QUAT_W-1:0]           cfg_data,
	output logic                        done,
	output logic signed [VEC_BITS-1:0]  rot_x,
	output logic signed [VEC_BITS-1:0]  rot_y,
	output logic signed [VEC_BITS-1:0]  rot_z,
	output logic                        clipped
);

	localparam int P_W     = QUAT_W + 1;
	localparam int PV_W    = P_W + VEC_BITS;
	localparam int U_W     = PV_W + 1;
	localparam int SH      = 2 * QUAT_FRAC;
	localparam int ACC_NAT = (VEC_BITS + 38 > SH + 2) ? VEC_BITS + 38 : SH + 2;
	localparam int ACC_W   = (ACC_NAT > 64) ? 64 : ACC_NAT;
	localparam int C_W     = ACC_W - SH;
	localparam int SUM_W   = ((C_W > VEC_BITS) ? C_W : VEC_BITS) + 1;

	localparam quat_reg_t W_RESET = QUAT_W'(64'd1 << QUAT_FRAC);
	localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SH - 1);

	// vector part, negated for the conjugate rotation
	function automatic logic signed [P_W-1:0] peff(input quat_reg_t q, input logic rev);
		logic signed [P_W-1:0] p;
		p = {q[QUAT_W-1], q};
		return rev ? -p : p;
	endfunction

	quat_reg_t quat_w_q, quat_x_q, quat_y_q, quat_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= W_RESET;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QW: quat_w_q <= cfg_data;
				REG_QX: quat_x_q <= cfg_data;
				REG_QY: quat_y_q <= cfg_data;
				REG_QZ: quat_z_q <= cfg_data;
			endcase
		end
	end

	assign busy = 1'b0;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	logic mode_s1, mode_s2, mode_s3;

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		mode_s2 <= mode_s1;
		mode_s3 <= mode_s2;
	end

	logic signed [VEC_BITS-1:0] vin [3];
	logic signed [P_W-1:0]      p2 [3];
	logic signed [P_W-1:0]      p4 [3];
	logic signed [QUAT_W-1:0]   w4;

	assign vin[0] = vec_x;
	assign vin[1] = vec_y;
	assign vin[2] = vec_z;

	assign p2[0] = peff(quat_x_q, mode_s1);
	assign p2[1] = peff(quat_y_q, mode_s1);
	assign p2[2] = peff(quat_z_q, mode_s1);
	assign p4[0] = peff(quat_x_q, mode_s3);
	assign p4[1] = peff(quat_y_q, mode_s3);
	assign p4[2] = peff(quat_z_q, mode_s3);
	assign w4    = quat_w_q;

	logic signed [VEC_BITS-1:0] v_s1 [3];
	logic signed [VEC_BITS-1:0] v_s2 [3];
	logic signed [VEC_BITS-1:0] v_s3 [3];
	logic signed [VEC_BITS-1:0] v_s4 [3];
	logic signed [VEC_BITS-1:0] v_s5 [3];
	logic signed [PV_W-1:0]     pva_s2 [3];
	logic signed [PV_W-1:0]     pvb_s2 [3];
	logic signed [U_W-1:0]      u_s3 [3];
	logic signed [ACC_W-1:0]    pua_s4 [3];
	logic signed [ACC_W-1:0]    pub_s4 [3];
	logic signed [ACC_W-1:0]    wu_s4 [3];
	logic signed [ACC_W-1:0]    acc [3];
	logic signed [C_W-1:0]      c_s5 [3];
	logic signed [SUM_W-1:0]    sum [3];
	logic [2:0]                 sat;
	logic signed [VEC_BITS-1:0] rot_s6 [3];
	logic [2:0]                 sat_s6;

	for (genvar k = 0; k < 3; k++) begin : g_axis
		localparam int K1 = (k + 1) % 3;
		localparam int K2 = (k + 2) % 3;

		// t = p x u, then both correction terms summed at scale 2^SH
		assign acc[k] = (wu_s4[k] <<< 1) + ((pua_s4[k] - pub_s4[k]) <<< 1) + HALF;
		assign sum[k] = SUM_W'(c_s5[k]) + SUM_W'(v_s5[k]);
		assign sat[k] = !((&sum[k][SUM_W-1:VEC_BITS-1]) || !(|sum[k][SUM_W-1:VEC_BITS-1]));

		always_ff @(posedge clk) begin
			v_s1[k]   <= vin[k];
			v_s2[k]   <= v_s1[k];
			v_s3[k]   <= v_s2[k];
			v_s4[k]   <= v_s3[k];
			v_s5[k]   <= v_s4[k];
			pva_s2[k] <= PV_W'(p2[K1] * v_s1[K2]);
			pvb_s2[k] <= PV_W'(p2[K2] * v_s1[K1]);
			u_s3[k]   <= U_W'(pva_s2[k]) - U_W'(pvb_s2[k]);
			pua_s4[k] <= ACC_W'(p4[K1] * u_s3[K2]);
			pub_s4[k] <= ACC_W'(p4[K2] * u_s3[K1]);
			wu_s4[k]  <= ACC_W'(w4 * u_s3[k]);
			c_s5[k]   <= acc[k][ACC_W-1:SH];
			sat_s6[k] <= sat[k];
			if (sat[k]) begin
				rot_s6[k] <= sum[k][SUM_W-1] ? {1'b1, {(VEC_BITS-1){1'b0}}}
				                             : {1'b0, {(VEC_BITS-1){1'b1}}};
			end else begin
				rot_s6[k] <= sum[k][VEC_BITS-1:0];
			end
		end
	end

	assign done    = valid_s6;
	assign rot_x   = rot_s6[0];
	assign rot_y   = rot_s6[1];
	assign rot_z   = rot_s6[2];
	assign clipped = |sat_s6;

endmodule

// ===== hw/rtl/qvr_checker.sv =====
// Port-level checker for the quaternion vector rotator, bound to its top level.
// Depends on qvr_pkg for the pipeline depth.
module qvr_checker
	import qvr_pkg::*;
#(
	parameter int VEC_BITS = 24
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       done,
	input logic signed [VEC_BITS-1:0] rot_x,
	input logic signed [VEC_BITS-1:0] rot_y,
	input logic signed [VEC_BITS-1:0] rot_z,
	input logic                       clipped
);

	localparam logic [VEC_BITS-1:0] VMAX = {1'b0, {(VEC_BITS-1){1'b1}}};
	localparam logic [VEC_BITS-1:0] VMIN = {1'b1, {(VEC_BITS-1){1'b0}}};

	// every accepted item yields its result a fixed depth later
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_DEPTH done)
		else $error("accepted item produced no result");

	// no result without an item accepted that depth earlier
	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##PIPE_DEPTH !done)
		else $error("result without an accepted item");

	// a clip flag implies some coordinate sits at a rail
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (rot_x == VMAX || rot_x == VMIN || rot_y == VMAX ||
			rot_y == VMIN || rot_z == VMAX || rot_z == VMIN))
		else $error("clipped set with no saturated coordinate");

endmodule

bind quaternion_vector_rotate qvr_checker #(.VEC_BITS(VEC_BITS)) u_qvr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.rot_x(rot_x),
	.rot_y(rot_y),
	.rot_z(rot_z),
	.clipped(clipped)
);
